[rtl/tbw_pkg.sv]
// Package for the triangle barycentric weight pipeline: payload structs,
// fixed arithmetic widths and constants. No dependencies.
`default_nettype none

package tbw_pkg;

    localparam int COORD_BITS  = 16;
    localparam int WEIGHT_FRAC = 16;

    localparam int DIFF_W = COORD_BITS + 1;     // corner differences
    localparam int PROD_W = 2 * DIFF_W;         // one cross-product term
    localparam int COMP_W = PROD_W + 1;         // one cross component
    localparam int MAG_W  = PROD_W;             // |component|, at most 2^(2*COORD_BITS+1)
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 2;           // squared length of a cross product

    localparam int WA_W      = 23;              // weight_a / weight_b width
    localparam int WC_W      = 24;              // weight_c width
    localparam int ROOT_BITS = WA_W;
    localparam int Q_BITS    = 2 * ROOT_BITS;   // quotient bits fed to the square root
    localparam int REM_W     = SUM_W + Q_BITS + 2;
    localparam int SR_W      = ROOT_BITS + 3;

    localparam logic [WA_W:0] WEIGHT_ONE = (WA_W + 1)'(1) << WEIGHT_FRAC;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] a_z;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] b_z;
        logic signed [COORD_BITS-1:0] c_x;
        logic signed [COORD_BITS-1:0] c_y;
        logic signed [COORD_BITS-1:0] c_z;
        logic signed [COORD_BITS-1:0] p_x;
        logic signed [COORD_BITS-1:0] p_y;
        logic signed [COORD_BITS-1:0] p_z;
    } tbw_in_t;

    typedef struct packed {
        logic [WA_W-1:0]        weight_a;
        logic [WA_W-1:0]        weight_b;
        logic signed [WC_W-1:0] weight_c;
        logic                   degenerate;
        logic                   saturated;
    } tbw_out_t;

endpackage

`default_nettype wire

[rtl/triangle_barycentric_weights_top.sv]
// Top level of the barycentric weight pipeline: cross products, area
// ratio by long division and digit-by-digit square root. Uses tbw_pkg.
`default_nettype none

// Usage
// - Input channel s_valid / s_ready / s_data carries one triangle (corners
//   A, B, C) and one query point P per transfer, signed Q8.8 coordinates.
// - Result channel m_valid / m_ready / m_data returns weight_a, weight_b
//   (unsigned Q7.16), weight_c (signed Q8.16) plus degenerate and saturated.
// - An input transfer passes through five stages of differences, products,
//   squares and sums, one stage of overflow check, 46 long-division stages
//   (one quotient bit each), 23 square-root stages (one root bit each) and
//   the output register before it shows on m_valid.
// - One item per cycle unless the receiver stalls; every stage holds its
//   own item and valid bit, so transfers may follow each other back to back.
// - When the receiver stalls with a result waiting, the whole pipeline
//   holds and s_ready drops; nothing is dropped or repeated. Empty slots
//   travel down the pipeline with their items and are not squeezed out.
// - Reset clears all valid bits; payload registers are left as they are.
// - A zero-area triangle returns zero weights with degenerate set.
module triangle_barycentric_weights_top (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire tbw_pkg::tbw_in_t s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output tbw_pkg::tbw_out_t    m_data
);

    localparam int CB    = tbw_pkg::COORD_BITS;
    localparam int DW    = tbw_pkg::DIFF_W;
    localparam int PW    = tbw_pkg::PROD_W;
    localparam int CW    = tbw_pkg::COMP_W;
    localparam int MW    = tbw_pkg::MAG_W;
    localparam int QW    = tbw_pkg::SQ_W;
    localparam int SW    = tbw_pkg::SUM_W;
    localparam int QB    = tbw_pkg::Q_BITS;
    localparam int RB    = tbw_pkg::ROOT_BITS;
    localparam int RW    = tbw_pkg::REM_W;
    localparam int SRW   = tbw_pkg::SR_W;
    localparam int WAW   = tbw_pkg::WA_W;
    localparam int WCW   = tbw_pkg::WC_W;
    localparam int FR2   = 2 * tbw_pkg::WEIGHT_FRAC;
    localparam int LAST  = QB + RB;           // index of the last tail stage
    localparam int NSTG  = 6 + QB + RB + 1;   // stages including the output register

    localparam logic signed [WCW+1:0] WC_HI = (WCW + 2)'((1 << (WCW - 1)) - 1);
    localparam logic signed [WCW+1:0] WC_LO = -(WCW + 2)'(1 << (WCW - 1));

    // Global advance: move everything when the output slot is free or taken.
    logic advance;
    logic v_reg [0:NSTG-1];

    assign advance = m_ready || !v_reg[NSTG-1];
    assign s_ready = advance;
    assign m_valid = v_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSTG; i++) v_reg[i] <= 1'b0;
        end else if (advance) begin
            v_reg[0] <= s_valid;
            for (int i = 1; i < NSTG; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    // Stage 1: edge vectors ab, ac, bp, cp, ap
    logic signed [CB-1:0] a_c [3], b_c [3], c_c [3], p_c [3];
    logic signed [DW-1:0] d_reg [5][3];

    always_comb begin
        a_c[0] = s_data.a_x; a_c[1] = s_data.a_y; a_c[2] = s_data.a_z;
        b_c[0] = s_data.b_x; b_c[1] = s_data.b_y; b_c[2] = s_data.b_z;
        c_c[0] = s_data.c_x; c_c[1] = s_data.c_y; c_c[2] = s_data.c_z;
        p_c[0] = s_data.p_x; p_c[1] = s_data.p_y; p_c[2] = s_data.p_z;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < 3; i++) begin
                d_reg[0][i] <= $signed({a_c[i][CB-1], a_c[i]}) - $signed({b_c[i][CB-1], b_c[i]});
                d_reg[1][i] <= $signed({a_c[i][CB-1], a_c[i]}) - $signed({c_c[i][CB-1], c_c[i]});
                d_reg[2][i] <= $signed({b_c[i][CB-1], b_c[i]}) - $signed({p_c[i][CB-1], p_c[i]});
                d_reg[3][i] <= $signed({c_c[i][CB-1], c_c[i]}) - $signed({p_c[i][CB-1], p_c[i]});
                d_reg[4][i] <= $signed({a_c[i][CB-1], a_c[i]}) - $signed({p_c[i][CB-1], p_c[i]});
            end
        end
    end

    // Stages 2-5: cross products (area, sub-area A, sub-area B), squared lengths.
    // Cross 0 is the full triangle, 1 weighs A, 2 weighs B.
    logic signed [PW-1:0] pl_reg [3][3];
    logic signed [PW-1:0] pr_reg [3][3];
    logic [MW-1:0]        mag_reg [3][3];
    logic [QW-1:0]        sq_reg [3][3];
    logic [SW-1:0]        sum_reg [3];

    for (genvar k = 0; k < 3; k++) begin : g_cross
        localparam int U = (k == 0) ? 0 : (k == 1) ? 2 : 3;
        localparam int V = (k == 0) ? 1 : (k == 1) ? 3 : 4;
        for (genvar i = 0; i < 3; i++) begin : g_comp
            localparam int I1 = (i + 1) % 3;
            localparam int I2 = (i + 2) % 3;
            logic signed [CW-1:0] comp;
            logic signed [CW-1:0] comp_neg;

            assign comp = $signed({pl_reg[k][i][PW-1], pl_reg[k][i]})
                        - $signed({pr_reg[k][i][PW-1], pr_reg[k][i]});
            assign comp_neg = -comp;

            always_ff @(posedge aclk) begin
                if (advance) begin
                    pl_reg[k][i]  <= d_reg[U][I1] * d_reg[V][I2];
                    pr_reg[k][i]  <= d_reg[U][I2] * d_reg[V][I1];
                    mag_reg[k][i] <= comp[CW-1] ? comp_neg[MW-1:0] : comp[MW-1:0];
                    sq_reg[k][i]  <= mag_reg[k][i] * mag_reg[k][i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                sum_reg[k] <= {2'b00, sq_reg[k][0]} + {2'b00, sq_reg[k][1]}
                            + {2'b00, sq_reg[k][2]};
            end
        end
    end

    // Stage 6 and division: Q = floor(num * 2^(2F) / area), one bit a stage.
    // A quotient of 2^QB or more already clips the weight, so flag it up front.
    logic [SW-1:0] den_reg  [0:QB-1];
    logic          degen_reg[0:LAST];
    logic          sat_reg  [2][0:LAST];
    logic [RW-1:0] rem_reg  [2][0:QB];
    logic [QB-1:0] quo_reg  [2][0:QB];

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [RW-1:0] num_sh;
        logic [RW-1:0] den_top;

        assign num_sh  = {{(RW - SW - FR2){1'b0}}, sum_reg[l+1], {FR2{1'b0}}};
        assign den_top = {{(RW - SW - QB){1'b0}}, sum_reg[0], {QB{1'b0}}};

        always_ff @(posedge aclk) begin
            if (advance) begin
                rem_reg[l][0] <= num_sh;
                quo_reg[l][0] <= '0;
                sat_reg[l][0] <= (num_sh >= den_top);
            end
        end

        for (genvar i = 0; i < QB; i++) begin : g_div
            localparam int K = QB - 1 - i;
            logic [RW-1:0] trial;
            logic          ge;

            assign trial = {{(RW - SW){1'b0}}, den_reg[i]} << K;
            assign ge    = (rem_reg[l][i] >= trial);

            always_ff @(posedge aclk) begin
                if (advance) begin
                    rem_reg[l][i+1] <= ge ? rem_reg[l][i] - trial : rem_reg[l][i];
                    quo_reg[l][i+1] <= {quo_reg[l][i][QB-2:0], ge};
                    sat_reg[l][i+1] <= sat_reg[l][i];
                end
            end
        end

        // Square root, two radicand bits per stage, one root bit out.
        logic [QB-1:0]  qsh_reg  [1:RB];
        logic [SRW-1:0] srem_reg [1:RB];
        logic [RB-1:0]  root_reg [1:RB];

        for (genvar j = 0; j < RB; j++) begin : g_sqrt
            logic [QB-1:0]  src_q;
            logic [SRW-1:0] src_rem;
            logic [RB-1:0]  src_root;
            logic [SRW-1:0] rem_sh;
            logic [SRW-1:0] trial;
            logic           ge;

            if (j == 0) begin : g_first
                assign src_q    = quo_reg[l][QB];
                assign src_rem  = '0;
                assign src_root = '0;
            end else begin : g_next
                assign src_q    = qsh_reg[j];
                assign src_rem  = srem_reg[j];
                assign src_root = root_reg[j];
            end

            assign rem_sh = {src_rem[SRW-3:0], src_q[QB-1:QB-2]};
            assign trial  = {{(SRW - RB - 2){1'b0}}, src_root, 2'b01};
            assign ge     = (rem_sh >= trial);

            always_ff @(posedge aclk) begin
                if (advance) begin
                    qsh_reg[j+1]  <= {src_q[QB-3:0], 2'b00};
                    srem_reg[j+1] <= ge ? rem_sh - trial : rem_sh;
                    root_reg[j+1] <= {src_root[RB-2:0], ge};
                    sat_reg[l][QB+1+j] <= sat_reg[l][QB+j];
                end
            end
        end

        logic [WAW-1:0] w_clip;
        assign w_clip = sat_reg[l][LAST] ? {WAW{1'b1}} : root_reg[RB];
    end

    // Carry area and zero-area flag along the tail.
    always_ff @(posedge aclk) begin
        if (advance) begin
            den_reg[0]   <= sum_reg[0];
            degen_reg[0] <= (sum_reg[0] == '0);
            for (int i = 0; i < QB - 1; i++) den_reg[i+1] <= den_reg[i];
            for (int i = 0; i < LAST; i++) degen_reg[i+1] <= degen_reg[i];
        end
    end

    // Output stage: weight_c from the clipped weights, then clip it too.
    logic [WAW:0]          w_sum;
    logic signed [WCW+1:0] wc_wide;
    logic signed [WCW+1:0] wc_clip;
    logic                  wc_sat;
    tbw_pkg::tbw_out_t     res;
    tbw_pkg::tbw_out_t     out_reg;

    always_comb begin
        w_sum   = {1'b0, g_lane[0].w_clip} + {1'b0, g_lane[1].w_clip};
        wc_wide = $signed({1'b0, tbw_pkg::WEIGHT_ONE}) - $signed({1'b0, w_sum});
        wc_sat  = 1'b0;
        wc_clip = wc_wide;
        if (wc_wide > WC_HI) begin
            wc_clip = WC_HI;
            wc_sat  = 1'b1;
        end else if (wc_wide < WC_LO) begin
            wc_clip = WC_LO;
            wc_sat  = 1'b1;
        end
        if (degen_reg[LAST]) begin
            res = '0;
            res.degenerate = 1'b1;
        end else begin
            res.weight_a   = g_lane[0].w_clip;
            res.weight_b   = g_lane[1].w_clip;
            res.weight_c   = wc_clip[WCW-1:0];
            res.degenerate = 1'b0;
            res.saturated  = sat_reg[0][LAST] || sat_reg[1][LAST] || wc_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_data = out_reg;

    // Checks
    logic signed [WCW+1:0] chk_wc;
    assign chk_wc = $signed({1'b0, tbw_pkg::WEIGHT_ONE}) - $signed({3'b000, m_data.weight_a})
                  - $signed({3'b000, m_data.weight_b});

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.degenerate) |->
        (m_data.weight_a == '0 && m_data.weight_b == '0 &&
         m_data.weight_c == '0 && !m_data.saturated))
        else $error("degenerate result with nonzero fields");

    a_wc_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.degenerate && !m_data.saturated) |->
        (chk_wc == {{2{m_data.weight_c[WCW-1]}}, m_data.weight_c}))
        else $error("weight_c does not complete the unit sum");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input held off with empty output register");

endmodule

`default_nettype wire
